// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Each macro expands to one labelled concurrent assertion on i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define SRC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sntp_response_checker: assertion failed");

// Assertion that is also checked while reset is asserted.
`define SRC_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("sntp_response_checker: reset assertion failed");

`endif

// ===== hw/rtl/sntp_rc_pkg.sv =====
// ----------------------------------------------------------------------------
// SNTP response checker package
// Types, verdict codes and fixed constants shared by the checker modules.
// ----------------------------------------------------------------------------
package sntp_rc_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned JOB_DEPTH = 2;

    localparam logic [IDX_W-1:0] IDX_HEADER    = 4'd0;
    localparam logic [IDX_W-1:0] IDX_ORIG_SEC  = 4'd6;
    localparam logic [IDX_W-1:0] IDX_ORIG_FRAC = 4'd7;
    localparam logic [IDX_W-1:0] IDX_TX_SEC    = 4'd10;
    localparam logic [IDX_W-1:0] IDX_TX_FRAC   = 4'd11;
    localparam logic [IDX_W-1:0] FULL_WORDS    = 4'd12;

    localparam logic [WORD_W-1:0] NTP_TO_UNIX     = 32'd2208988800;
    localparam logic [WORD_W-1:0] MIN_UTC_DEFAULT = 32'd1704067200;
    localparam logic [WORD_W-1:0] MAX_UTC_DEFAULT = 32'd4102444800;

    localparam logic [2:0] VERSION_3    = 3'd3;
    localparam logic [2:0] VERSION_4    = 3'd4;
    localparam logic [2:0] MODE_SERVER  = 3'd4;
    localparam logic [1:0] LEAP_ALARM   = 2'd3;
    localparam logic [7:0] STRATUM_MAX  = 8'd15;
    localparam logic [7:0] STRATUM_KOD  = 8'd0;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ORIG_SEC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIG_FRAC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_UTC   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_UTC   = 2'd3;

    // Verdict codes on the result channel.
    localparam logic [1:0] VERDICT_IGNORED  = 2'd0;
    localparam logic [1:0] VERDICT_DENIED   = 2'd1;
    localparam logic [1:0] VERDICT_ACCEPTED = 2'd2;

    // Classification handed from the front end to the back end.
    localparam logic [1:0] KIND_IGNORE = 2'd0;
    localparam logic [1:0] KIND_DENY   = 2'd1;
    localparam logic [1:0] KIND_WINDOW = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] orig_seconds;
        logic [WORD_W-1:0] orig_fraction;
        logic [WORD_W-1:0] min_utc;
        logic [WORD_W-1:0] max_utc;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        kind;
        logic [WORD_W-1:0] tx_seconds;
    } t_job;

endpackage

// ===== hw/rtl/sntp_rc_if.sv =====
// ----------------------------------------------------------------------------
// SNTP response checker channels
// Valid/ready channels for datagram words and for verdicts.
// ----------------------------------------------------------------------------
interface sntp_rc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic        last;

    modport source (output valid, output word, output last, input ready);
    modport sink (input valid, input word, input last, output ready);
endinterface

interface sntp_rc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [31:0] utc_seconds;

    modport source (output valid, output verdict, output utc_seconds, input ready);
    modport sink (input valid, input verdict, input utc_seconds, output ready);
endinterface

// ===== hw/rtl/sntp_rc_fifo.sv =====
// ----------------------------------------------------------------------------
// SNTP response checker job queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module sntp_rc_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sntp_rc_pkg::t_job   i_push_job,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_not_empty,
    output sntp_rc_pkg::t_job   o_head_job
);
    localparam int unsigned DEPTH = sntp_rc_pkg::JOB_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sntp_rc_pkg::t_job r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wptr;
    logic [PTR_W-1:0]  n_rptr;
    logic [CNT_W-1:0]  n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full      = (r_count == FULL_CNT);
    assign o_not_empty = (r_count != '0);
    assign o_head_job  = r_slot[r_rptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_push_job;
        end
    end
endmodule

// ===== hw/rtl/sntp_rc_front.sv =====
// ----------------------------------------------------------------------------
// SNTP response checker front end
// Takes datagram words, captures the fields of interest and classifies the
// reply on its last word.
// ----------------------------------------------------------------------------
module sntp_rc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sntp_rc_in_if.sink         i_in,
    input  sntp_rc_pkg::t_cfg  i_cfg,
    input  logic               i_job_full,
    output logic               o_job_push,
    output sntp_rc_pkg::t_job  o_job
);
    logic [sntp_rc_pkg::IDX_W-1:0]  r_idx;
    logic [sntp_rc_pkg::IDX_W-1:0]  n_idx;
    logic                           r_match;
    logic                           n_match;
    logic [sntp_rc_pkg::WORD_W-1:0] r_header;
    logic [sntp_rc_pkg::WORD_W-1:0] r_tx_sec;
    logic [sntp_rc_pkg::WORD_W-1:0] r_tx_frac;
    logic [sntp_rc_pkg::WORD_W-1:0] tx_frac_eff;
    logic                           beat;
    logic [2:0]                     version;
    logic [2:0]                     mode;
    logic [7:0]                     stratum;
    logic [1:0]                     leap;

    assign i_in.ready = !i_job_full;
    assign beat       = i_in.valid && !i_job_full;
    assign o_job_push = beat && i_in.last;

    assign leap    = r_header[31:30];
    assign version = r_header[29:27];
    assign mode    = r_header[26:24];
    assign stratum = r_header[23:16];

    always_comb begin
        n_idx   = r_idx;
        n_match = r_match;
        if (beat) begin
            if (i_in.last) begin
                n_idx   = '0;
                n_match = 1'b1;
            end else begin
                if (r_idx < sntp_rc_pkg::FULL_WORDS) begin
                    n_idx = r_idx + 1'b1;
                end
                if ((r_idx == sntp_rc_pkg::IDX_ORIG_SEC
                        && i_in.word != i_cfg.orig_seconds)
                    || (r_idx == sntp_rc_pkg::IDX_ORIG_FRAC
                        && i_in.word != i_cfg.orig_fraction)) begin
                    n_match = 1'b0;
                end
            end
        end
    end

    // The reply is full only if the last beat arrives at word eleven or later,
    // so the header, the originate check and the transmit seconds are already
    // stored; only the transmit fraction may come with this beat.
    assign tx_frac_eff = (r_idx == sntp_rc_pkg::IDX_TX_FRAC) ? i_in.word : r_tx_frac;

    always_comb begin
        o_job.tx_seconds = r_tx_sec;
        if (r_idx < sntp_rc_pkg::IDX_TX_FRAC) begin
            o_job.kind = sntp_rc_pkg::KIND_IGNORE;
        end else if ((version != sntp_rc_pkg::VERSION_3 && version != sntp_rc_pkg::VERSION_4)
                     || mode != sntp_rc_pkg::MODE_SERVER || !r_match) begin
            o_job.kind = sntp_rc_pkg::KIND_IGNORE;
        end else if (stratum == sntp_rc_pkg::STRATUM_KOD) begin
            o_job.kind = sntp_rc_pkg::KIND_DENY;
        end else if (leap == sntp_rc_pkg::LEAP_ALARM || stratum > sntp_rc_pkg::STRATUM_MAX
                     || (r_tx_sec == '0 && tx_frac_eff == '0)) begin
            o_job.kind = sntp_rc_pkg::KIND_IGNORE;
        end else begin
            o_job.kind = sntp_rc_pkg::KIND_WINDOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_match <= 1'b1;
        end else begin
            r_idx   <= n_idx;
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat) begin
            if (r_idx == sntp_rc_pkg::IDX_HEADER) begin
                r_header <= i_in.word;
            end
            if (r_idx == sntp_rc_pkg::IDX_TX_SEC) begin
                r_tx_sec <= i_in.word;
            end
            if (r_idx == sntp_rc_pkg::IDX_TX_FRAC) begin
                r_tx_frac <= i_in.word;
            end
        end
    end
endmodule

// ===== hw/rtl/sntp_rc_back.sv =====
// ----------------------------------------------------------------------------
// SNTP response checker back end
// Converts the transmit stamp to UTC, applies the time window and holds the
// verdict until the receiver takes it.
// ----------------------------------------------------------------------------
module sntp_rc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sntp_rc_pkg::t_cfg  i_cfg,
    input  logic               i_job_not_empty,
    input  sntp_rc_pkg::t_job  i_job,
    output logic               o_job_pop,
    sntp_rc_out_if.source      o_out
);
    logic                           r_valid;
    logic [1:0]                     r_verdict;
    logic [sntp_rc_pkg::WORD_W-1:0] r_utc;
    logic [1:0]                     n_verdict;
    logic [sntp_rc_pkg::WORD_W-1:0] n_utc;
    logic [sntp_rc_pkg::WORD_W-1:0] secs;
    logic                           in_window;

    assign o_job_pop = i_job_not_empty && (!r_valid || o_out.ready);

    assign secs      = i_job.tx_seconds - sntp_rc_pkg::NTP_TO_UNIX;
    assign in_window = (secs >= i_cfg.min_utc) && (secs < i_cfg.max_utc);

    always_comb begin
        n_verdict = sntp_rc_pkg::VERDICT_IGNORED;
        n_utc     = '0;
        unique case (i_job.kind)
            sntp_rc_pkg::KIND_DENY: begin
                n_verdict = sntp_rc_pkg::VERDICT_DENIED;
            end
            sntp_rc_pkg::KIND_WINDOW: begin
                if (in_window) begin
                    n_verdict = sntp_rc_pkg::VERDICT_ACCEPTED;
                    n_utc     = secs;
                end
            end
            default: begin
                n_verdict = sntp_rc_pkg::VERDICT_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_job_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_verdict <= n_verdict;
            r_utc     <= n_utc;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.verdict     = r_verdict;
    assign o_out.utc_seconds = r_utc;
endmodule

// ===== hw/rtl/sntp_response_checker.sv =====
// ----------------------------------------------------------------------------
// SNTP response checker
// Validates an SNTP v3 or v4 server reply word by word and gives one verdict.
// ----------------------------------------------------------------------------
// The reply enters on i_in, one 32-bit word per beat in network order, with
// last set on its final word. Each datagram gives exactly one verdict beat
// on o_out: ignored, denied (stratum zero) or accepted with UTC seconds.
// Words after the twelfth are not examined.
// Throughput is one word per cycle while the job queue is not full. The verdict
// passes from the beat that carries last through the job queue into the verdict register.
// A two-entry job queue sits between the word front end and the verdict
// register, so words keep flowing while a verdict waits; i_in.ready drops
// only when the queue is full because the receiver holds o_out.ready low.
// The four configuration registers are written through i_cfg_we, i_cfg_idx
// and i_cfg_data; write them only while no datagram is in flight.
// Synchronous reset empties the queue, drops o_out.valid, restarts the word
// count and loads the register defaults.
// ----------------------------------------------------------------------------
module sntp_response_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    sntp_rc_in_if.sink                             i_in,
    sntp_rc_out_if.source                          o_out,
    input  logic                                   i_cfg_we,
    input  logic [sntp_rc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sntp_rc_pkg::WORD_W-1:0]         i_cfg_data
);
    sntp_rc_pkg::t_cfg r_cfg;
    sntp_rc_pkg::t_job push_job;
    sntp_rc_pkg::t_job head_job;
    logic              job_push;
    logic              job_full;
    logic              job_pop;
    logic              job_not_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.orig_seconds  <= '0;
            r_cfg.orig_fraction <= '0;
            r_cfg.min_utc       <= sntp_rc_pkg::MIN_UTC_DEFAULT;
            r_cfg.max_utc       <= sntp_rc_pkg::MAX_UTC_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sntp_rc_pkg::REG_ORIG_SEC:  r_cfg.orig_seconds  <= i_cfg_data;
                sntp_rc_pkg::REG_ORIG_FRAC: r_cfg.orig_fraction <= i_cfg_data;
                sntp_rc_pkg::REG_MIN_UTC:   r_cfg.min_utc       <= i_cfg_data;
                sntp_rc_pkg::REG_MAX_UTC:   r_cfg.max_utc       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sntp_rc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (r_cfg),
        .i_job_full (job_full),
        .o_job_push (job_push),
        .o_job      (push_job)
    );

    sntp_rc_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (job_push),
        .i_push_job  (push_job),
        .o_full      (job_full),
        .i_pop       (job_pop),
        .o_not_empty (job_not_empty),
        .o_head_job  (head_job)
    );

    sntp_rc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_job_not_empty (job_not_empty),
        .i_job           (head_job),
        .o_job_pop       (job_pop),
        .o_out           (o_out)
    );
endmodule

// ===== hw/rtl/sntp_rc_checker.sv =====
// ----------------------------------------------------------------------------
// SNTP response checker port assertions
// Checks the verdict channel of the top level over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sntp_rc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_verdict,
    input logic [31:0] i_out_utc_seconds
);
    `SRC_ASSERT_RST(a_reset_clears_valid, !i_rst_n |=> !i_out_valid)
    `SRC_ASSERT(a_stall_holds, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_verdict) && $stable(i_out_utc_seconds))
    `SRC_ASSERT(a_verdict_code, i_out_valid |-> i_out_verdict != 2'd3)
    `SRC_ASSERT(a_utc_only_accepted, i_out_valid && i_out_verdict != sntp_rc_pkg::VERDICT_ACCEPTED |-> i_out_utc_seconds == '0)
endmodule

bind sntp_response_checker sntp_rc_checker u_sntp_rc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_verdict     (o_out.verdict),
    .i_out_utc_seconds (o_out.utc_seconds)
);

// ===== dv/sntp_response_checker_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SNTP response checker testbench
// Sends SNTP reply words into the checker and compares every verdict beat
// with a predictor that follows each reply word as it is accepted. Directed
// replies cover every verdict rule, the order in which the rules apply, the
// era rollover and the register extremes. Random replies, mostly well formed,
// then run under several register settings. The sender idles in random
// bursts, the receiver stalls, and once the receiver holds off for long
// enough that the checker has to stall its input.
// ----------------------------------------------------------------------------
module sntp_response_checker_test;

    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned PHASE_WORDS  = 200;

    typedef struct {
        logic [1:0]                     verdict;
        logic [sntp_rc_pkg::WORD_W-1:0] utc;
    } t_verdict_beat;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [sntp_rc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [sntp_rc_pkg::WORD_W-1:0]    i_cfg_data;

    sntp_rc_in_if  in_ch ();
    sntp_rc_out_if out_ch ();

    sntp_response_checker u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    logic [sntp_rc_pkg::WORD_W-1:0] cfg_orig_sec  = '0;
    logic [sntp_rc_pkg::WORD_W-1:0] cfg_orig_frac = '0;
    logic [sntp_rc_pkg::WORD_W-1:0] cfg_min_utc   = sntp_rc_pkg::MIN_UTC_DEFAULT;
    logic [sntp_rc_pkg::WORD_W-1:0] cfg_max_utc   = sntp_rc_pkg::MAX_UTC_DEFAULT;

    logic [sntp_rc_pkg::IDX_W-1:0]  rx_count   = '0;
    logic [sntp_rc_pkg::WORD_W-1:0] rx_header  = '0;
    logic                           rx_orig_ok = 1'b1;
    logic [sntp_rc_pkg::WORD_W-1:0] rx_tx_sec  = '0;
    logic [sntp_rc_pkg::WORD_W-1:0] rx_tx_frac = '0;

    t_verdict_beat                  pending_verdicts[$];
    logic [sntp_rc_pkg::WORD_W-1:0] reply[$];

    int unsigned mismatches   = 0;
    int unsigned burst_left   = 0;
    bit          sender_gaps  = 1'b0;
    int unsigned stall_mode   = 0;
    bit          hold_request = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #10ms;
        $display("sntp_response_checker regression: fail");
        $finish;
    end

    function automatic t_verdict_beat judge_reply();
        t_verdict_beat                  beat;
        logic [sntp_rc_pkg::WORD_W-1:0] utc;
        beat.verdict = sntp_rc_pkg::VERDICT_IGNORED;
        beat.utc     = '0;
        utc          = rx_tx_sec - sntp_rc_pkg::NTP_TO_UNIX;
        if (rx_count < sntp_rc_pkg::FULL_WORDS) return beat;
        if ((rx_header[29:27] != sntp_rc_pkg::VERSION_3
                && rx_header[29:27] != sntp_rc_pkg::VERSION_4)
                || rx_header[26:24] != sntp_rc_pkg::MODE_SERVER || !rx_orig_ok) return beat;
        if (rx_header[23:16] == sntp_rc_pkg::STRATUM_KOD) begin
            beat.verdict = sntp_rc_pkg::VERDICT_DENIED;
            return beat;
        end
        if (rx_header[31:30] == sntp_rc_pkg::LEAP_ALARM
                || rx_header[23:16] > sntp_rc_pkg::STRATUM_MAX
                || (rx_tx_sec == '0 && rx_tx_frac == '0)) return beat;
        if (utc < cfg_min_utc || utc >= cfg_max_utc) return beat;
        beat.verdict = sntp_rc_pkg::VERDICT_ACCEPTED;
        beat.utc     = utc;
        return beat;
    endfunction

    function automatic void track_word(input logic [sntp_rc_pkg::WORD_W-1:0] w,
            input logic lst);
        if (rx_count < sntp_rc_pkg::FULL_WORDS) begin
            case (rx_count)
                sntp_rc_pkg::IDX_HEADER:    rx_header = w;
                sntp_rc_pkg::IDX_ORIG_SEC:  if (w != cfg_orig_sec) rx_orig_ok = 1'b0;
                sntp_rc_pkg::IDX_ORIG_FRAC: if (w != cfg_orig_frac) rx_orig_ok = 1'b0;
                sntp_rc_pkg::IDX_TX_SEC:    rx_tx_sec = w;
                sntp_rc_pkg::IDX_TX_FRAC:   rx_tx_frac = w;
                default: ;
            endcase
            rx_count = rx_count + 1'b1;
        end
        if (lst) begin
            pending_verdicts.push_back(judge_reply());
            rx_count   = '0;
            rx_header  = '0;
            rx_orig_ok = 1'b1;
            rx_tx_sec  = '0;
            rx_tx_frac = '0;
        end
    endfunction

    function automatic logic [sntp_rc_pkg::WORD_W-1:0] pack_header(input logic [1:0] leap,
            input logic [2:0] ver, input logic [2:0] mode, input logic [7:0] stratum);
        return {leap, ver, mode, stratum, 16'($urandom)};
    endfunction

    function automatic void make_reply(input logic [sntp_rc_pkg::WORD_W-1:0] utc);
        reply.delete();
        reply.push_back(pack_header(2'($urandom_range(0, 2)),
            $urandom_range(0, 1) ? sntp_rc_pkg::VERSION_4 : sntp_rc_pkg::VERSION_3,
            sntp_rc_pkg::MODE_SERVER, 8'($urandom_range(1, 15))));
        for (int k = 1; k < 12; k++) reply.push_back($urandom);
        reply[sntp_rc_pkg::IDX_ORIG_SEC]  = cfg_orig_sec;
        reply[sntp_rc_pkg::IDX_ORIG_FRAC] = cfg_orig_frac;
        reply[sntp_rc_pkg::IDX_TX_SEC]    = utc + sntp_rc_pkg::NTP_TO_UNIX;
    endfunction

    function automatic logic [sntp_rc_pkg::WORD_W-1:0] pick_utc();
        longint unsigned span;
        if (cfg_max_utc <= cfg_min_utc) return $urandom;
        span = longint'(cfg_max_utc) - longint'(cfg_min_utc);
        case ($urandom_range(0, 9))
            0: return cfg_min_utc;
            1: return cfg_max_utc - 1'b1;
            2: return cfg_min_utc - 1'b1;
            3: return cfg_max_utc;
            default: return cfg_min_utc + 32'(longint'($urandom) % span);
        endcase
    endfunction

    // Mostly well-formed replies with random content; the rest are broken
    // in one way each, or plain noise.
    function automatic void random_reply();
        logic [sntp_rc_pkg::WORD_W-1:0] hdr;
        int unsigned                    n;
        make_reply(pick_utc());
        hdr = reply[sntp_rc_pkg::IDX_HEADER];
        case ($urandom_range(0, 19))
            12: begin
                n = $urandom_range(1, 11);
                while (reply.size() > n) void'(reply.pop_back());
            end
            13: repeat ($urandom_range(1, 8)) reply.push_back($urandom);
            14: begin
                n = $urandom_range(0, 5);
                hdr[29:27] = 3'((n >= 3) ? n + 2 : n);
            end
            15: begin
                n = $urandom_range(0, 6);
                hdr[26:24] = 3'((n >= 4) ? n + 1 : n);
            end
            16: begin
                n = $urandom_range(6, 7);
                reply[n] = reply[n] ^ (32'd1 << $urandom_range(0, 31));
            end
            17: hdr[23:16] = $urandom_range(0, 1) ? sntp_rc_pkg::STRATUM_KOD
                                                  : 8'($urandom_range(16, 255));
            18: begin
                if ($urandom_range(0, 1)) begin
                    hdr[31:30] = sntp_rc_pkg::LEAP_ALARM;
                end else begin
                    reply[sntp_rc_pkg::IDX_TX_SEC]  = '0;
                    reply[sntp_rc_pkg::IDX_TX_FRAC] = '0;
                end
            end
            19: begin
                reply.delete();
                repeat ($urandom_range(1, 16)) reply.push_back($urandom);
                hdr = reply[sntp_rc_pkg::IDX_HEADER];
            end
            default: ;
        endcase
        reply[sntp_rc_pkg::IDX_HEADER] = hdr;
    endfunction

    task automatic send_word(input logic [sntp_rc_pkg::WORD_W-1:0] w, input logic lst);
        in_ch.valid <= 1'b1;
        in_ch.word  <= w;
        in_ch.last  <= lst;
        do @(posedge i_clk); while (!in_ch.ready);
        track_word(w, lst);
    endtask

    task automatic send_reply();
        foreach (reply[k]) begin
            if (sender_gaps) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    in_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(posedge i_clk);
                end
                burst_left--;
            end
            send_word(reply[k], k == reply.size() - 1);
        end
    endtask

    task automatic send_headed(input logic [1:0] leap, input logic [2:0] ver,
            input logic [2:0] mode, input logic [7:0] stratum);
        make_reply(cfg_min_utc);
        reply[sntp_rc_pkg::IDX_HEADER] = pack_header(leap, ver, mode, stratum);
        send_reply();
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sntp_rc_pkg::CFG_IDX_W-1:0] idx,
            input logic [sntp_rc_pkg::WORD_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        case (idx)
            sntp_rc_pkg::REG_ORIG_SEC:  cfg_orig_sec  = d;
            sntp_rc_pkg::REG_ORIG_FRAC: cfg_orig_frac = d;
            sntp_rc_pkg::REG_MIN_UTC:   cfg_min_utc   = d;
            sntp_rc_pkg::REG_MAX_UTC:   cfg_max_utc   = d;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [sntp_rc_pkg::WORD_W-1:0] os,
            input logic [sntp_rc_pkg::WORD_W-1:0] of,
            input logic [sntp_rc_pkg::WORD_W-1:0] mn,
            input logic [sntp_rc_pkg::WORD_W-1:0] mx);
        settle();
        write_reg(sntp_rc_pkg::REG_ORIG_SEC, os);
        write_reg(sntp_rc_pkg::REG_ORIG_FRAC, of);
        write_reg(sntp_rc_pkg::REG_MIN_UTC, mn);
        write_reg(sntp_rc_pkg::REG_MAX_UTC, mx);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_default_window();
        sender_gaps = 1'b0;
        stall_mode  = 0;
        make_reply(sntp_rc_pkg::MIN_UTC_DEFAULT);
        send_reply();
        make_reply(sntp_rc_pkg::MAX_UTC_DEFAULT - 1);
        send_reply();
        make_reply(sntp_rc_pkg::MAX_UTC_DEFAULT);
        send_reply();
        make_reply(sntp_rc_pkg::MIN_UTC_DEFAULT - 1);
        send_reply();
        // Transmit seconds just past the NTP era rollover still land in the window.
        make_reply(sntp_rc_pkg::MIN_UTC_DEFAULT);
        reply[sntp_rc_pkg::IDX_TX_SEC] = 32'd1;
        send_reply();
        make_reply(sntp_rc_pkg::MIN_UTC_DEFAULT);
        reply[sntp_rc_pkg::IDX_TX_SEC]  = '0;
        reply[sntp_rc_pkg::IDX_TX_FRAC] = 32'd1;
        send_reply();
        settle();
    endtask

    task automatic test_verdict_rules();
        sender_gaps = 1'b1;
        stall_mode  = 1;
        reply.delete();
        reply.push_back('1);
        send_reply();
        make_reply(cfg_min_utc);
        void'(reply.pop_back());
        send_reply();
        send_headed(2'd0, 3'd0, sntp_rc_pkg::MODE_SERVER, 8'd1);
        send_headed(2'd0, 3'd2, sntp_rc_pkg::MODE_SERVER, 8'd1);
        send_headed(2'd0, 3'd7, sntp_rc_pkg::MODE_SERVER, 8'd1);
        send_headed(2'd0, sntp_rc_pkg::VERSION_3, 3'd3, 8'd1);
        send_headed(2'd0, sntp_rc_pkg::VERSION_4, 3'd5, 8'd1);
        make_reply(cfg_min_utc);
        reply[sntp_rc_pkg::IDX_ORIG_SEC] = ~cfg_orig_sec;
        send_reply();
        make_reply(cfg_min_utc);
        reply[sntp_rc_pkg::IDX_ORIG_FRAC] = ~cfg_orig_frac;
        send_reply();
        send_headed(2'd0, sntp_rc_pkg::VERSION_4, sntp_rc_pkg::MODE_SERVER,
            sntp_rc_pkg::STRATUM_KOD);
        send_headed(sntp_rc_pkg::LEAP_ALARM, sntp_rc_pkg::VERSION_4, sntp_rc_pkg::MODE_SERVER,
            sntp_rc_pkg::STRATUM_KOD);
        send_headed(2'd0, sntp_rc_pkg::VERSION_4, 3'd3, sntp_rc_pkg::STRATUM_KOD);
        send_headed(sntp_rc_pkg::LEAP_ALARM, sntp_rc_pkg::VERSION_4, sntp_rc_pkg::MODE_SERVER,
            8'd1);
        send_headed(2'd0, sntp_rc_pkg::VERSION_3, sntp_rc_pkg::MODE_SERVER,
            sntp_rc_pkg::STRATUM_MAX);
        send_headed(2'd0, sntp_rc_pkg::VERSION_4, sntp_rc_pkg::MODE_SERVER, 8'd16);
        send_headed(2'd0, sntp_rc_pkg::VERSION_4, sntp_rc_pkg::MODE_SERVER, 8'd255);
        make_reply(cfg_min_utc);
        reply[sntp_rc_pkg::IDX_TX_SEC]  = '0;
        reply[sntp_rc_pkg::IDX_TX_FRAC] = '0;
        send_reply();
        make_reply(cfg_min_utc);
        reply.push_back('1);
        reply.push_back('0);
        reply.push_back('1);
        send_reply();
        reply.delete();
        repeat (12) reply.push_back('0);
        send_reply();
        settle();
    endtask

    task automatic test_register_extremes();
        sender_gaps = 1'b1;
        stall_mode  = 2;
        program_regs('1, '1, '0, '1);
        make_reply('0);
        send_reply();
        make_reply(32'hFFFF_FFFE);
        send_reply();
        make_reply('1);
        send_reply();
        make_reply('0);
        reply[sntp_rc_pkg::IDX_ORIG_SEC] = '0;
        send_reply();
        // An empty window accepts nothing but still lets a denial through.
        program_regs('0, '0, '1, '1);
        make_reply('1);
        send_reply();
        send_headed(2'd0, sntp_rc_pkg::VERSION_4, sntp_rc_pkg::MODE_SERVER,
            sntp_rc_pkg::STRATUM_KOD);
        program_regs($urandom, $urandom, 32'd2000000000, 32'd1900000000);
        make_reply(32'd1950000000);
        send_reply();
        settle();
    endtask

    task automatic test_backpressure();
        program_regs($urandom, $urandom, sntp_rc_pkg::MIN_UTC_DEFAULT,
            sntp_rc_pkg::MAX_UTC_DEFAULT);
        sender_gaps  = 1'b0;
        stall_mode   = 0;
        hold_request = 1'b1;
        repeat (30) begin
            if ($urandom_range(0, 1)) begin
                reply.delete();
                reply.push_back($urandom);
            end else begin
                random_reply();
            end
            send_reply();
        end
        settle();
    endtask

    task automatic run_phase(input logic [sntp_rc_pkg::WORD_W-1:0] os,
            input logic [sntp_rc_pkg::WORD_W-1:0] of,
            input logic [sntp_rc_pkg::WORD_W-1:0] mn,
            input logic [sntp_rc_pkg::WORD_W-1:0] mx,
            input bit gaps, input int unsigned mode);
        int unsigned sent;
        program_regs(os, of, mn, mx);
        sender_gaps = gaps;
        stall_mode  = mode;
        sent        = 0;
        while (sent < PHASE_WORDS) begin
            random_reply();
            sent += reply.size();
            send_reply();
        end
    endtask

    task automatic test_random_traffic();
        logic [sntp_rc_pkg::WORD_W-1:0] mn;
        logic [sntp_rc_pkg::WORD_W-1:0] mx;
        run_phase($urandom, $urandom, sntp_rc_pkg::MIN_UTC_DEFAULT,
            sntp_rc_pkg::MAX_UTC_DEFAULT, 1'b1, 1);
        run_phase('1, '0, '0, '1, 1'b0, 0);
        mn = $urandom;
        mx = (mn > 32'hFFFF_0000) ? '1 : mn + $urandom_range(1, 5000);
        run_phase($urandom, $urandom, mn, mx, 1'b1, 2);
        mn = $urandom;
        run_phase($urandom, $urandom, mn, mn, 1'b1, 1);
        run_phase($urandom, $urandom, 32'hF000_0000, 32'h1000_0000, 1'b0, 2);
        run_phase($urandom, $urandom, $urandom, $urandom, 1'b1, 0);
        settle();
    endtask

    initial begin : receiver
        int unsigned tick;
        tick = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: out_ch.ready <= ((tick % 5) < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin : verdict_check
        t_verdict_beat want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: verdict beat with none expected, actual verdict %0d utc %0d",
                    $time, out_ch.verdict, out_ch.utc_seconds);
                mismatches++;
            end else begin
                want = pending_verdicts.pop_front();
                if (out_ch.verdict !== want.verdict) begin
                    $display("%0t: verdict expected %0d actual %0d",
                        $time, want.verdict, out_ch.verdict);
                    mismatches++;
                end
                if (out_ch.utc_seconds !== want.utc) begin
                    $display("%0t: utc_seconds expected %0d actual %0d",
                        $time, want.utc, out_ch.utc_seconds);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.word  <= '0;
        in_ch.last  <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_window();
        test_verdict_rules();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();
        settle();
        if (mismatches == 0) begin
            $display("sntp_response_checker regression: pass");
        end else begin
            $display("sntp_response_checker regression: fail");
        end
        $finish;
    end

endmodule
